### hdl/prz_pkg.sv
`timescale 1ns / 1ps

package prz_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int PTR_BITS   = $clog2(WINDOW_MAX);
    localparam int LEN_BITS   = 7;
    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = 8;
    localparam int RATIO_BITS = INT_BITS + FRAC_BITS;
    localparam int SUM_BITS   = 30;
    localparam int SQ_BITS    = 54;
    localparam int D_BITS     = 61;
    localparam int MAG_BITS   = 31;
    localparam int MSQ_BITS   = 2 * MAG_BITS;
    localparam int THR_BITS   = 16;
    localparam int TT_BITS    = 2 * THR_BITS;
    localparam int RHS_BITS   = TT_BITS + D_BITS;
    localparam int MUL_BITS   = 32;
    localparam int ADDR_BITS  = 4;

    localparam logic [1:0] REG_LEG_A     = 2'd0;
    localparam logic [1:0] REG_LEG_B     = 2'd1;
    localparam logic [1:0] REG_WINDOW    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    localparam logic [31:0]         LEG_A_RESET  = 32'd0;
    localparam logic [31:0]         LEG_B_RESET  = 32'd1;
    localparam logic [LEN_BITS-1:0] WINDOW_RESET = 7'd20;
    localparam logic [THR_BITS-1:0] THR_RESET    = 16'd512;
    localparam logic [LEN_BITS-1:0] WINDOW_MIN   = 7'd2;
    localparam logic [LEN_BITS-1:0] WINDOW_TOP   = 7'd64;

    localparam logic DIR_BUY  = 1'b0;
    localparam logic DIR_SELL = 1'b1;

    typedef enum logic [1:0] {
        POS_FLAT  = 2'd0,
        POS_LONG  = 2'd1,
        POS_SHORT = 2'd2
    } pos_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_SQ,
        ST_SUB,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_M9,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [31:0]        instrument_id;
        logic signed [31:0] price;
    } in_item_t;

    typedef struct packed {
        logic [31:0] signal_instrument;
        logic        direction;
        logic [1:0]  position_after;
        logic        is_last;
    } out_item_t;

endpackage

### hdl/pair_ratio_zscore_signal.sv
`timescale 1ns / 1ps

// Channel   | Ports                       | Payload
// input     | s_valid, s_ready, s_data    | instrument_id, price
// result    | m_valid, m_ready, m_data    | signal_instrument, direction, position_after, is_last
// config    | psel..pready (APB)          | leg_a_id, leg_b_id, window_len, entry_threshold
//
// A tick for neither leg, or a leg update with an unset leg, goes from check back to idle.
// A full tick runs the restoring divider (one quotient bit a cycle, skipped on
// saturation), then the ring read; one shared 32x32 multiplier sets the tail.
// The ratio ring is a 64-entry memory with a registered read.
// aresetn is synchronous; reset clears control, sums and prices, not the ring.
// A new tick is taken in idle while the two result requests still wait.
module pair_ratio_zscore_signal (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  prz_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output prz_pkg::out_item_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prz_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int PB = prz_pkg::PRICE_BITS;
    localparam int RB = prz_pkg::RATIO_BITS;

    prz_pkg::state_t state_reg, state_next;

    logic [31:0]                     leg_a_reg, leg_b_reg;
    logic [prz_pkg::LEN_BITS-1:0]    wl_reg;
    logic [prz_pkg::THR_BITS-1:0]    thr_reg;
    logic [PB-1:0]                   pa_reg, pb_reg;
    logic                            matched_reg;
    logic [PB-2:0]                   rem_reg;
    logic [RB-1:0]                   dsh_reg;
    logic [RB-1:0]                   ratio_reg;
    logic [4:0]                      cnt_reg;
    logic [prz_pkg::PTR_BITS-1:0]    wp_reg;
    logic [prz_pkg::LEN_BITS-1:0]    fill_reg;
    logic [prz_pkg::SUM_BITS-1:0]    sum_reg;
    logic [prz_pkg::SQ_BITS-1:0]     sq_reg;
    logic [2*prz_pkg::MUL_BITS-1:0]  prod_reg;
    logic [prz_pkg::D_BITS-1:0]      nq_reg, d_reg;
    logic [prz_pkg::MAG_BITS-1:0]    mag_reg;
    logic                            pos_side_reg, neg_side_reg;
    logic [prz_pkg::TT_BITS-1:0]     tt_reg;
    logic [prz_pkg::MSQ_BITS-1:0]    msq_reg;
    logic [prz_pkg::RHS_BITS-1:0]    rhs_reg;
    prz_pkg::pos_t                   pos_reg;
    logic [1:0]                      ocnt_reg;
    prz_pkg::out_item_t              ofirst_reg, osecond_reg;

    logic [RB-1:0]                   ring [prz_pkg::WINDOW_MAX];
    logic [RB-1:0]                   rd_reg;

    logic [prz_pkg::MUL_BITS-1:0]    mul_a, mul_b;
    logic [prz_pkg::LEN_BITS-1:0]    n_eff;
    logic                            cfg_wr, accept, hit_a, hit_b, pa_ok, pb_ok, full;
    logic                            sat;
    logic [PB-1:0]                   trial;
    logic [prz_pkg::PTR_BITS-1:0]    rd_addr;
    logic [prz_pkg::LEN_BITS-1:0]    fill_new;
    logic [prz_pkg::SUM_BITS:0]      nr_diff, sr_diff;
    logic                            gt, lt;
    logic [prz_pkg::RHS_BITS-1:0]    lhs_big;
    logic [prz_pkg::MSQ_BITS:0]      lhs_small;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign s_ready = (state_reg == prz_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign hit_a   = (s_data.instrument_id == leg_a_reg);
    assign hit_b   = (s_data.instrument_id == leg_b_reg);
    assign pa_ok   = (pa_reg != '0) && !pa_reg[PB-1];
    assign pb_ok   = (pb_reg != '0) && !pb_reg[PB-1];
    assign sat     = {8'd0, pa_reg} >= {pb_reg, 8'd0};
    assign trial   = {rem_reg, dsh_reg[RB-1]};
    assign rd_addr = wp_reg - n_eff[prz_pkg::PTR_BITS-1:0];
    assign full    = (fill_reg >= n_eff);
    assign fill_new = full ? fill_reg : fill_reg + 1'b1;

    assign m_valid = (ocnt_reg != 2'd0);
    assign m_data  = (ocnt_reg == 2'd2) ? ofirst_reg : osecond_reg;

    always_comb begin
        if (wl_reg < prz_pkg::WINDOW_MIN) begin
            n_eff = prz_pkg::WINDOW_MIN;
        end else if (wl_reg > prz_pkg::WINDOW_TOP) begin
            n_eff = prz_pkg::WINDOW_TOP;
        end else begin
            n_eff = wl_reg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            prz_pkg::REG_LEG_A:     prdata = leg_a_reg;
            prz_pkg::REG_LEG_B:     prdata = leg_b_reg;
            prz_pkg::REG_WINDOW:    prdata = {25'd0, wl_reg};
            prz_pkg::REG_THRESHOLD: prdata = {16'd0, thr_reg};
            default:                prdata = '0;
        endcase
    end

    // n*r against the sum gives the sign and size of the deviation
    assign nr_diff = {1'b0, prod_reg[prz_pkg::SUM_BITS-1:0]} - {1'b0, sum_reg};
    assign sr_diff = {1'b0, sum_reg} - {1'b0, prod_reg[prz_pkg::SUM_BITS-1:0]};

    // |z| > T/256 as (256|X|)^2 > T^2 D, |z| < 0.5 as D > 4 X^2
    assign lhs_big   = {{(prz_pkg::RHS_BITS - prz_pkg::MSQ_BITS - 16){1'b0}}, msq_reg, 16'd0};
    assign gt        = lhs_big > rhs_reg;
    assign lhs_small = {msq_reg, 1'b0} << 1;
    assign lt        = {{(prz_pkg::MSQ_BITS + 1 - prz_pkg::D_BITS){1'b0}}, d_reg} > lhs_small;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            prz_pkg::ST_READ: begin
                mul_a = {8'd0, ratio_reg};
                mul_b = {8'd0, ratio_reg};
            end
            prz_pkg::ST_SQ: begin
                mul_a = {8'd0, rd_reg};
                mul_b = {8'd0, rd_reg};
            end
            prz_pkg::ST_M1: begin
                mul_a = {25'd0, n_eff};
                mul_b = sq_reg[31:0];
            end
            prz_pkg::ST_M2: begin
                mul_a = {25'd0, n_eff};
                mul_b = {10'd0, sq_reg[prz_pkg::SQ_BITS-1:32]};
            end
            prz_pkg::ST_M3: begin
                mul_a = {2'd0, sum_reg};
                mul_b = {2'd0, sum_reg};
            end
            prz_pkg::ST_M4: begin
                mul_a = {25'd0, n_eff};
                mul_b = {8'd0, ratio_reg};
            end
            prz_pkg::ST_M5: begin
                mul_a = {16'd0, thr_reg};
                mul_b = {16'd0, thr_reg};
            end
            prz_pkg::ST_M6: begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, mag_reg};
            end
            prz_pkg::ST_M7: begin
                mul_a = tt_reg;
                mul_b = d_reg[31:0];
            end
            prz_pkg::ST_M8: begin
                mul_a = tt_reg;
                mul_b = {3'd0, d_reg[prz_pkg::D_BITS-1:32]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prz_pkg::ST_IDLE:   if (accept) state_next = prz_pkg::ST_CHECK;
            prz_pkg::ST_CHECK: begin
                if (!matched_reg || !pa_ok || !pb_ok) begin
                    state_next = prz_pkg::ST_IDLE;
                end else if (sat) begin
                    state_next = prz_pkg::ST_READ;
                end else begin
                    state_next = prz_pkg::ST_DIV;
                end
            end
            prz_pkg::ST_DIV:    if (cnt_reg == 5'd23) state_next = prz_pkg::ST_READ;
            prz_pkg::ST_READ:   state_next = prz_pkg::ST_SQ;
            prz_pkg::ST_SQ:     state_next = prz_pkg::ST_SUB;
            prz_pkg::ST_SUB: begin
                state_next = (fill_new < n_eff) ? prz_pkg::ST_IDLE : prz_pkg::ST_M1;
            end
            prz_pkg::ST_M1:     state_next = prz_pkg::ST_M2;
            prz_pkg::ST_M2:     state_next = prz_pkg::ST_M3;
            prz_pkg::ST_M3:     state_next = prz_pkg::ST_M4;
            prz_pkg::ST_M4:     state_next = prz_pkg::ST_M5;
            prz_pkg::ST_M5: begin
                state_next = (d_reg == '0) ? prz_pkg::ST_IDLE : prz_pkg::ST_M6;
            end
            prz_pkg::ST_M6:     state_next = prz_pkg::ST_M7;
            prz_pkg::ST_M7:     state_next = prz_pkg::ST_M8;
            prz_pkg::ST_M8:     state_next = prz_pkg::ST_M9;
            prz_pkg::ST_M9:     state_next = prz_pkg::ST_DECIDE;
            prz_pkg::ST_DECIDE: if (ocnt_reg == 2'd0) state_next = prz_pkg::ST_IDLE;
            default:            state_next = prz_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == prz_pkg::ST_READ) begin
            rd_reg <= ring[rd_addr];
            ring[wp_reg] <= ratio_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            prz_pkg::ST_CHECK: begin
                ratio_reg <= '1;
                rem_reg   <= {8'd0, pa_reg[PB-2:8]};
                dsh_reg   <= {pa_reg[7:0], 16'd0};
            end
            prz_pkg::ST_DIV: begin
                dsh_reg <= {dsh_reg[RB-2:0], 1'b0};
                if (trial >= pb_reg) begin
                    rem_reg   <= (PB-1)'(trial - pb_reg);
                    ratio_reg <= {ratio_reg[RB-2:0], 1'b1};
                end else begin
                    rem_reg   <= trial[PB-2:0];
                    ratio_reg <= {ratio_reg[RB-2:0], 1'b0};
                end
            end
            prz_pkg::ST_M2: nq_reg <= prod_reg[prz_pkg::D_BITS-1:0];
            prz_pkg::ST_M3: nq_reg <= nq_reg + {prod_reg[prz_pkg::D_BITS-33:0], 32'd0};
            prz_pkg::ST_M4: begin
                d_reg <= (nq_reg > prod_reg[prz_pkg::D_BITS-1:0])
                       ? nq_reg - prod_reg[prz_pkg::D_BITS-1:0] : '0;
            end
            prz_pkg::ST_M5: begin
                pos_side_reg <= !nr_diff[prz_pkg::SUM_BITS] && (nr_diff != '0);
                neg_side_reg <= nr_diff[prz_pkg::SUM_BITS];
                mag_reg      <= nr_diff[prz_pkg::SUM_BITS] ? sr_diff : nr_diff;
            end
            prz_pkg::ST_M6: tt_reg  <= prod_reg[prz_pkg::TT_BITS-1:0];
            prz_pkg::ST_M7: msq_reg <= prod_reg[prz_pkg::MSQ_BITS-1:0];
            prz_pkg::ST_M8: rhs_reg <= {{(prz_pkg::RHS_BITS - 64){1'b0}}, prod_reg};
            prz_pkg::ST_M9: begin
                rhs_reg <= rhs_reg + {prod_reg[prz_pkg::RHS_BITS-33:0], 32'd0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prz_pkg::ST_IDLE;
            leg_a_reg   <= prz_pkg::LEG_A_RESET;
            leg_b_reg   <= prz_pkg::LEG_B_RESET;
            wl_reg      <= prz_pkg::WINDOW_RESET;
            thr_reg     <= prz_pkg::THR_RESET;
            pa_reg      <= '0;
            pb_reg      <= '0;
            matched_reg <= 1'b0;
            cnt_reg     <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            pos_reg     <= prz_pkg::POS_FLAT;
            ocnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    prz_pkg::REG_LEG_A:     leg_a_reg <= pwdata;
                    prz_pkg::REG_LEG_B:     leg_b_reg <= pwdata;
                    prz_pkg::REG_THRESHOLD: thr_reg   <= pwdata[prz_pkg::THR_BITS-1:0];
                    prz_pkg::REG_WINDOW: begin
                        wl_reg   <= pwdata[prz_pkg::LEN_BITS-1:0];
                        wp_reg   <= '0;
                        fill_reg <= '0;
                        sum_reg  <= '0;
                        sq_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                matched_reg <= hit_a || hit_b;
                if (hit_a) pa_reg <= s_data.price;
                if (hit_b) pb_reg <= s_data.price;
            end
            if (state_reg == prz_pkg::ST_CHECK) cnt_reg <= '0;
            if (state_reg == prz_pkg::ST_DIV) cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == prz_pkg::ST_SQ) begin
                sq_reg <= sq_reg + prod_reg[prz_pkg::SQ_BITS-1:0];
            end
            if (state_reg == prz_pkg::ST_SUB) begin
                // drop the oldest ratio once the window is full
                if (full) begin
                    sq_reg  <= sq_reg - prod_reg[prz_pkg::SQ_BITS-1:0];
                    sum_reg <= sum_reg + prz_pkg::SUM_BITS'(ratio_reg)
                             - prz_pkg::SUM_BITS'(rd_reg);
                end else begin
                    sum_reg <= sum_reg + prz_pkg::SUM_BITS'(ratio_reg);
                end
                wp_reg   <= wp_reg + 1'b1;
                fill_reg <= fill_new;
            end
            if (m_valid && m_ready) ocnt_reg <= ocnt_reg - 1'b1;
            if (state_reg == prz_pkg::ST_DECIDE && ocnt_reg == 2'd0) begin
                ofirst_reg.signal_instrument  <= leg_a_reg;
                ofirst_reg.is_last            <= 1'b0;
                osecond_reg.signal_instrument <= leg_b_reg;
                osecond_reg.is_last           <= 1'b1;
                if (pos_side_reg && gt && pos_reg != prz_pkg::POS_SHORT) begin
                    pos_reg                    <= prz_pkg::POS_SHORT;
                    ofirst_reg.direction       <= prz_pkg::DIR_SELL;
                    osecond_reg.direction      <= prz_pkg::DIR_BUY;
                    ofirst_reg.position_after  <= prz_pkg::POS_SHORT;
                    osecond_reg.position_after <= prz_pkg::POS_SHORT;
                    ocnt_reg                   <= 2'd2;
                end else if (neg_side_reg && gt && pos_reg != prz_pkg::POS_LONG) begin
                    pos_reg                    <= prz_pkg::POS_LONG;
                    ofirst_reg.direction       <= prz_pkg::DIR_BUY;
                    osecond_reg.direction      <= prz_pkg::DIR_SELL;
                    ofirst_reg.position_after  <= prz_pkg::POS_LONG;
                    osecond_reg.position_after <= prz_pkg::POS_LONG;
                    ocnt_reg                   <= 2'd2;
                end else if (lt && pos_reg != prz_pkg::POS_FLAT) begin
                    pos_reg                    <= prz_pkg::POS_FLAT;
                    ofirst_reg.position_after  <= prz_pkg::POS_FLAT;
                    osecond_reg.position_after <= prz_pkg::POS_FLAT;
                    ocnt_reg                   <= 2'd2;
                    if (pos_reg == prz_pkg::POS_LONG) begin
                        ofirst_reg.direction  <= prz_pkg::DIR_SELL;
                        osecond_reg.direction <= prz_pkg::DIR_BUY;
                    end else begin
                        ofirst_reg.direction  <= prz_pkg::DIR_BUY;
                        osecond_reg.direction <= prz_pkg::DIR_SELL;
                    end
                end
            end
        end
    end

endmodule

### hdl/prz_checker.sv
`timescale 1ns / 1ps

module prz_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input prz_pkg::out_item_t            m_data,
    input logic                          pready
);

    // hold a stalled result request
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    // the second signal of a pair follows at once with the same position
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.is_last |=>
            m_valid && m_data.is_last &&
            m_data.position_after == $past(m_data.position_after) &&
            m_data.direction != $past(m_data.direction))
        else $error("broken signal pair");

    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.position_after != 2'd3)
        else $error("bad position code");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind pair_ratio_zscore_signal prz_checker u_prz_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

### dv/pair_ratio_zscore_signal_test.sv
`timescale 1ns / 1ps

module pair_ratio_zscore_signal_test;
    import prz_pkg::*;

    localparam int SIG_DEPTH = 16;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pair_ratio_zscore_signal dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // signal predictor state
    logic [31:0]        leg_a_q;
    logic [31:0]        leg_b_q;
    logic [LEN_BITS-1:0] wlen_q;
    logic [THR_BITS-1:0] thr_q;
    logic [31:0]        price_a_q;
    logic [31:0]        price_b_q;
    logic [23:0]        ratio_hist [WINDOW_MAX];
    logic [5:0]         hist_ptr;
    logic [6:0]         hist_fill;
    logic [63:0]        ratio_total;
    logic [63:0]        ratio_sq_total;
    pos_t               pair_pos;

    // expected signal requests, written by the predictor, read by the checker
    out_item_t          sig_fifo [SIG_DEPTH];
    int                 sig_wr;
    int                 sig_rd;
    int                 mismatch_count;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 rx_hold_cycles;
    int                 base_a;
    int                 base_b;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // receiver: random back-pressure plus an optional long hold-off
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // sample mid-cycle; the request is taken at the next rising edge
    always @(negedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sig_wr == sig_rd) begin
                $error("unexpected signal request: %p", m_data);
                mismatch_count++;
            end else begin
                want = sig_fifo[sig_rd % SIG_DEPTH];
                sig_rd++;
                if (m_data.signal_instrument !== want.signal_instrument) begin
                    $error("signal_instrument expected %h actual %h",
                           want.signal_instrument, m_data.signal_instrument);
                    mismatch_count++;
                end
                if (m_data.direction !== want.direction) begin
                    $error("direction expected %b actual %b", want.direction, m_data.direction);
                    mismatch_count++;
                end
                if (m_data.position_after !== want.position_after) begin
                    $error("position_after expected %0d actual %0d",
                           want.position_after, m_data.position_after);
                    mismatch_count++;
                end
                if (m_data.is_last !== want.is_last) begin
                    $error("is_last expected %b actual %b", want.is_last, m_data.is_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_pair(logic dir_a);
        out_item_t sig;
        sig.signal_instrument = leg_a_q;
        sig.direction = dir_a;
        sig.position_after = pair_pos;
        sig.is_last = 1'b0;
        sig_fifo[sig_wr % SIG_DEPTH] = sig;
        sig_wr++;
        sig.signal_instrument = leg_b_q;
        sig.direction = ~dir_a;
        sig.is_last = 1'b1;
        sig_fifo[sig_wr % SIG_DEPTH] = sig;
        sig_wr++;
    endtask

    task automatic predict_tick(in_item_t tick);
        int n;
        logic [23:0] ratio;
        logic [23:0] oldest;
        logic [63:0] nq;
        logic [63:0] ss;
        logic [63:0] var_d;
        logic [63:0] nr;
        logic [63:0] mag;
        logic [127:0] m8;
        logic [127:0] big_lhs;
        logic [127:0] big_rhs;
        logic [127:0] m2;
        if (tick.instrument_id != leg_a_q && tick.instrument_id != leg_b_q) return;
        if (tick.instrument_id == leg_a_q) price_a_q = tick.price;
        if (tick.instrument_id == leg_b_q) price_b_q = tick.price;
        if (price_a_q == 0 || price_a_q[31] || price_b_q == 0 || price_b_q[31]) return;
        n = wlen_q;
        if (n < 2) n = 2;
        if (n > WINDOW_MAX) n = WINDOW_MAX;
        if ((price_a_q / price_b_q) >= 256) ratio = 24'hFFFFFF;
        else ratio = 24'(({price_a_q, 16'h0}) / {16'h0, price_b_q});
        if (hist_fill >= n) begin
            oldest = ratio_hist[(hist_ptr + WINDOW_MAX - n) % WINDOW_MAX];
            ratio_total = ratio_total - oldest;
            ratio_sq_total = ratio_sq_total - 64'(oldest) * 64'(oldest);
        end
        ratio_hist[hist_ptr] = ratio;
        ratio_total = ratio_total + ratio;
        ratio_sq_total = ratio_sq_total + 64'(ratio) * 64'(ratio);
        hist_ptr = hist_ptr + 1'b1;
        if (hist_fill < n) hist_fill++;
        if (hist_fill < n) return;
        nq = 64'(n) * ratio_sq_total;
        ss = ratio_total * ratio_total;
        var_d = (nq > ss) ? nq - ss : 64'd0;
        if (var_d == 0) return;
        nr = 64'(n) * ratio;
        mag = (nr > ratio_total) ? nr - ratio_total : ratio_total - nr;
        m8 = 128'(mag) << 8;
        big_lhs = m8 * m8;
        big_rhs = 128'(thr_q) * 128'(thr_q) * 128'(var_d);
        if (nr > ratio_total && big_lhs > big_rhs && pair_pos != POS_SHORT) begin
            pair_pos = POS_SHORT;
            push_pair(DIR_SELL);
        end else if (nr < ratio_total && big_lhs > big_rhs && pair_pos != POS_LONG) begin
            pair_pos = POS_LONG;
            push_pair(DIR_BUY);
        end else begin
            m2 = 128'(mag) << 1;
            if (128'(var_d) > m2 * m2 && pair_pos != POS_FLAT) begin
                if (pair_pos == POS_LONG) begin
                    pair_pos = POS_FLAT;
                    push_pair(DIR_SELL);
                end else begin
                    pair_pos = POS_FLAT;
                    push_pair(DIR_BUY);
                end
            end
        end
    endtask

    task automatic send_tick(logic [31:0] id, logic [31:0] price);
        in_item_t tick;
        logic taken;
        tick.instrument_id = id;
        tick.price = price;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= tick;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        predict_tick(tick);
    endtask

    // hold off until every signal has arrived and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (sig_wr != sig_rd) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LEG_A:     leg_a_q = value;
            REG_LEG_B:     leg_b_q = value;
            REG_THRESHOLD: thr_q = value[THR_BITS-1:0];
            REG_WINDOW: begin
                wlen_q = value[LEN_BITS-1:0];
                hist_ptr = '0;
                hist_fill = '0;
                ratio_total = '0;
                ratio_sq_total = '0;
            end
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic random_leg_tick();
        int pick;
        logic [31:0] price;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_tick($urandom, $urandom);
        end else if (pick < 12) begin
            price = ($urandom_range(1) == 1) ? 32'd0 : (32'h80000000 | $urandom);
            send_tick(($urandom_range(1) == 1) ? leg_a_q : leg_b_q, price);
        end else if (pick < 15) begin
            send_tick(($urandom_range(1) == 1) ? leg_a_q : leg_b_q, $urandom & 32'h7FFFFFFF);
        end else if (pick < 60) begin
            price = base_a + $urandom_range(0, base_a / 20);
            if ($urandom_range(9) == 0) price = price * $urandom_range(2, 3);
            if ($urandom_range(9) == 0) price = price / 2 + 1;
            send_tick(leg_a_q, price);
        end else begin
            send_tick(leg_b_q, base_b + $urandom_range(0, base_b / 50));
        end
    endtask

    task automatic test_directed();
        apb_write(REG_WINDOW, 32'd2);
        apb_write(REG_THRESHOLD, 32'd0);
        send_tick(32'd5, 32'd1000);
        send_tick(leg_a_q, 32'd0);
        send_tick(leg_b_q, 32'h80000000);
        send_tick(leg_a_q, 32'd1000);
        send_tick(leg_b_q, 32'd1000);
        send_tick(leg_a_q, 32'd2000);
        send_tick(leg_a_q, 32'd1000);
        send_tick(leg_a_q, 32'd1000);
        send_tick(leg_a_q, 32'h7FFFFFFF);
        send_tick(leg_b_q, 32'd1);
        send_tick(leg_b_q, 32'h7FFFFFFF);
        send_tick(leg_a_q, 32'd1);
        send_tick(leg_a_q, 32'hFFFFFFFF);
        send_tick(32'hFFFFFFFF, 32'd77);
        drain();
        apb_write(REG_WINDOW, 32'd3);
        apb_write(REG_THRESHOLD, 32'd65535);
        send_tick(leg_a_q, 32'd1000);
        send_tick(leg_a_q, 32'd1000);
        send_tick(leg_a_q, 32'd1100);
        send_tick(leg_a_q, 32'd1050);
        drain();
        // one id on both legs: ratio stays 1.0, no variance
        apb_write(REG_LEG_A, 32'd7);
        apb_write(REG_LEG_B, 32'd7);
        apb_write(REG_WINDOW, 32'd2);
        send_tick(32'd7, 32'd500);
        send_tick(32'd7, 32'd900);
        send_tick(32'd7, 32'd900);
        drain();
    endtask

    task automatic test_random_phase(int tx_pct, int rx_pct, logic [31:0] win,
                                     logic [31:0] thr, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        apb_write(REG_LEG_A, $urandom);
        apb_write(REG_LEG_B, ($urandom_range(1) == 1) ? 32'hFFFFFFFF : $urandom);
        apb_write(REG_WINDOW, win);
        apb_write(REG_THRESHOLD, thr);
        base_a = $urandom_range(1000, 2000000);
        base_b = $urandom_range(1000, 2000000);
        repeat (count) random_leg_tick();
        drain();
    endtask

    task automatic test_back_pressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apb_write(REG_WINDOW, 32'd2);
        apb_write(REG_THRESHOLD, 32'd100);
        // make sure leg B holds a usable price before the stall
        send_tick(leg_b_q, 32'd2000);
        rx_hold_cycles = 600;
        repeat (30) send_tick(leg_a_q, $urandom_range(1000, 3000));
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sig_wr = 0;
        sig_rd = 0;
        mismatch_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles = 0;
        leg_a_q = LEG_A_RESET;
        leg_b_q = LEG_B_RESET;
        wlen_q = WINDOW_RESET;
        thr_q = THR_RESET;
        price_a_q = '0;
        price_b_q = '0;
        hist_ptr = '0;
        hist_fill = '0;
        ratio_total = '0;
        ratio_sq_total = '0;
        pair_pos = POS_FLAT;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(36, 70, 32'd0, 32'd128, 70);
        test_random_phase(36, 70, 32'd64, 32'd512, 90);
        test_random_phase(70, 36, 32'd127, 32'd256, 80);
        test_random_phase(70, 36, 32'd5, 32'd65535, 40);
        test_random_phase(0, 0, 32'd1, 32'd0, 60);
        test_random_phase(0, 0, 32'd20, 32'd300, 80);
        test_back_pressure();
        drain();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/prz_pkg.sv
hdl/pair_ratio_zscore_signal.sv
hdl/prz_checker.sv
dv/pair_ratio_zscore_signal_test.sv
